// ===== rtl/lcfd_pkg.sv =====
// Shared types and constants for the LED chain frame driver.
`default_nettype none
package lcfd_pkg;

  // Default chain length and register reset value
  localparam int unsigned PIXELS_DEF      = 32;
  localparam int unsigned CHAN_W          = 8;
  localparam int unsigned PIXEL_W         = 3 * CHAN_W;
  localparam logic [7:0]  LATCH_TICKS_RST = 8'd1;

  // Register index, taken from paddr[2]
  localparam logic REG_IDX_LATCH_TICKS = 1'b0;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_BYTE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_LATCH = 2'd2
  } phase_e;

  // Byte order on the chain within one pixel
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_BLUE  = 2'd1,
    CH_GREEN = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    ST_READY = 3'd0,
    ST_EXEC  = 3'd1,
    ST_FILL  = 3'd2,
    ST_READ  = 3'd3,
    ST_HOLD  = 3'd4
  } seq_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic       status;
    logic       byte_valid;
    logic [7:0] out_byte;
    phase_e     phase;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/lcfd_store.sv =====
// Pixel frame store: one-port-write, one-port-read memory with per-entry valid bits.
`default_nettype none
module lcfd_store #(
  parameter  int unsigned Pixels = lcfd_pkg::PIXELS_DEF,
  localparam int unsigned AddrW  = (Pixels > 1) ? $clog2(Pixels) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [AddrW-1:0]            waddr_i,
  input  wire logic [lcfd_pkg::PIXEL_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AddrW-1:0]            raddr_i,
  output logic      [lcfd_pkg::PIXEL_W-1:0] rdata_o
);
  import lcfd_pkg::*;

  logic [PIXEL_W-1:0] mem_q [Pixels];
  logic [PIXEL_W-1:0] rd_q;
  logic [Pixels-1:0]  vld_q;
  logic               rvld_q;

  // Storage array, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // Written-since-reset flags; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/lcfd_seq.sv =====
// Item sequencer: phase control, store reads, broadcast fill walks and result register.
`default_nettype none
module lcfd_seq #(
  parameter  int unsigned Pixels = lcfd_pkg::PIXELS_DEF,
  localparam int unsigned AddrW  = (Pixels > 1) ? $clog2(Pixels) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire lcfd_pkg::item_t              in_item_i,
  input  wire logic [7:0]                   latch_ticks_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output lcfd_pkg::result_t                 out_res_o,
  output logic                              mem_we_o,
  output logic      [AddrW-1:0]             mem_waddr_o,
  output logic      [lcfd_pkg::PIXEL_W-1:0] mem_wdata_o,
  output logic                              mem_re_o,
  output logic      [AddrW-1:0]             mem_raddr_o,
  input  wire logic [lcfd_pkg::PIXEL_W-1:0] mem_rdata_i
);
  import lcfd_pkg::*;

  localparam logic [AddrW-1:0] LastPix = AddrW'(Pixels - 1);
  localparam logic [7:0]       PixLim  = 8'(Pixels);

  seq_state_e       state_q, state_d;
  phase_e           mode_q, mode_d;
  item_t            item_q, item_d;
  logic [7:0]       tick_q, tick_d;
  logic [AddrW-1:0] pix_q, pix_d;
  chan_e            ch_q, ch_d;
  logic [AddrW-1:0] fill_q, fill_d;
  result_t          res_q, res_d;
  result_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;

  result_t          res;
  logic             fin;
  logic             out_free;
  logic [7:0]       sel_byte;

  // Pick the channel byte from the pixel just read
  always_comb begin
    unique case (ch_q)
      CH_RED:   sel_byte = mem_rdata_i[CHAN_W-1:0];
      CH_BLUE:  sel_byte = mem_rdata_i[2*CHAN_W-1:CHAN_W];
      CH_GREEN: sel_byte = mem_rdata_i[3*CHAN_W-1:2*CHAN_W];
      default:  sel_byte = '0;
    endcase
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_READY);
  assign mem_wdata_o = {item_q.green, item_q.blue, item_q.red};

  // Next state, phase bookkeeping and memory requests
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    item_d      = item_q;
    tick_d      = tick_q;
    pix_d       = pix_q;
    ch_d        = ch_q;
    fill_d      = fill_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = item_q.position[AddrW-1:0];
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    fin         = 1'b0;
    res         = '{status: 1'b0, byte_valid: 1'b0, out_byte: 8'h00, phase: PH_IDLE};

    unique case (state_q)
      ST_READY: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (item_q.kind)
          KIND_SET: begin
            if (mode_q == PH_WRITE) begin
              res.status = 1'b1;
              fin        = 1'b1;
            end else if (item_q.position >= PixLim) begin
              fill_d  = '0;
              state_d = ST_FILL;
            end else begin
              mem_we_o = 1'b1;
              fin      = 1'b1;
            end
          end
          KIND_UPDATE: begin
            if (mode_q == PH_IDLE) begin
              mode_d   = PH_WRITE;
              pix_d    = '0;
              ch_d     = CH_RED;
              mem_re_o = 1'b1;
              state_d  = ST_READ;
            end else begin
              res.status = 1'b1;
              fin        = 1'b1;
            end
          end
          KIND_TICK: begin
            if (mode_q == PH_LATCH) begin
              if (tick_q == 8'd0) begin
                mode_d = PH_IDLE;
              end else begin
                tick_d = tick_q - 8'd1;
              end
            end
            fin = 1'b1;
          end
          KIND_BYTE: begin
            if (mode_q == PH_WRITE) begin
              if (pix_q == LastPix && ch_q == CH_GREEN) begin
                mode_d = PH_LATCH;
                tick_d = latch_ticks_i;
                fin    = 1'b1;
              end else begin
                // Step to the next channel, or the next pixel after green
                if (ch_q == CH_GREEN) begin
                  pix_d = pix_q + AddrW'(1);
                  ch_d  = CH_RED;
                end else if (ch_q == CH_RED) begin
                  ch_d = CH_BLUE;
                end else begin
                  ch_d = CH_GREEN;
                end
                mem_re_o    = 1'b1;
                mem_raddr_o = pix_d;
                state_d     = ST_READ;
              end
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      ST_FILL: begin
        // Broadcast write walks the whole store
        mem_we_o    = 1'b1;
        mem_waddr_o = fill_q;
        if (fill_q == LastPix) begin
          fin = 1'b1;
        end else begin
          fill_d = fill_q + AddrW'(1);
        end
      end
      ST_READ: begin
        res.byte_valid = 1'b1;
        res.out_byte   = sel_byte;
        fin            = 1'b1;
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_READY;
        end
      end
      default: state_d = ST_READY;
    endcase

    res.phase = mode_d;

    // Hand the finished word to the output register, or park it
    if (fin) begin
      if (out_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = ST_READY;
      end else begin
        res_d   = res;
        state_d = ST_HOLD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      mode_q      <= PH_IDLE;
      tick_q      <= '0;
      pix_q       <= '0;
      ch_q        <= CH_RED;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      tick_q      <= tick_d;
      pix_q       <= pix_d;
      ch_q        <= ch_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // A broadcast fill never runs while the chain is being written
  a_fill_not_writing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> mode_q != PH_WRITE)
    else $error("fill walk during write phase");

  // Store is read only for the byte stream
  a_read_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> mode_d == PH_WRITE && !mem_we_o)
    else $error("store read outside write phase");

  // A parked word means the output register is occupied
  a_hold_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("result parked with output register empty");

  // Emitted bytes only belong to the write phase
  a_byte_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.byte_valid |-> out_q.phase == PH_WRITE && !out_q.status)
    else $error("byte emitted outside write phase");

  // An accepted item moves straight into execution
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EXEC)
    else $error("accepted word not executed");

endmodule
`default_nettype wire

// ===== rtl/led_chain_frame_driver_core.sv =====
// Top level of the LED chain frame driver: stream ports, register port, store and sequencer.
//
//  channel   | dir | signals            | contents
//  ----------+-----+--------------------+---------------------------------------------
//  s_axis    | in  | tvalid/tready/...  | command word: kind, position, red, green, blue
//  m_axis    | out | tvalid/tready/...  | result word: status, byte_valid, out_byte, phase
//  apb       | in  | psel/penable/...   | latch_ticks register at byte address 0
//
// Flow: set pixel, tick, refused or final byte done finish without a store read; update
// and byte done with a byte to send add a registered store read before the result word.
// A broadcast set pixel walks the whole store, one store write per pixel.
// Reset clears phase, counters and per-pixel valid flags at once; no clearing pass.
// A stalled m_axis holds the pending word; one finished word can park inside the
// sequencer, after which s_axis stays not ready until m_axis drains.
`default_nettype none
module led_chain_frame_driver_core #(
  parameter int unsigned Pixels = lcfd_pkg::PIXELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // position[7:0], red[15:8], green[23:16], blue[31:24]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // out_byte[7:0], phase[9:8], zero[15:10]
  output logic      [1:0]  m_axis_tuser   // status[0], byte_valid[1]
);
  import lcfd_pkg::*;

  localparam int unsigned AddrW = (Pixels > 1) ? $clog2(Pixels) : 1;

  logic [7:0]         latch_ticks_q;
  logic               cfg_wr;
  item_t              item;
  result_t            res;
  logic               mem_we;
  logic               mem_re;
  logic [AddrW-1:0]   mem_waddr;
  logic [AddrW-1:0]   mem_raddr;
  logic [PIXEL_W-1:0] mem_wdata;
  logic [PIXEL_W-1:0] mem_rdata;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_LATCH_TICKS);
  assign prdata = (paddr[2] == REG_IDX_LATCH_TICKS) ? {24'h0, latch_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_ticks_q <= LATCH_TICKS_RST;
    end else if (cfg_wr) begin
      latch_ticks_q <= pwdata[7:0];
    end
  end

  // Unpack command word
  assign item.kind     = kind_e'(s_axis_tuser);
  assign item.position = s_axis_tdata[7:0];
  assign item.red      = s_axis_tdata[15:8];
  assign item.green    = s_axis_tdata[23:16];
  assign item.blue     = s_axis_tdata[31:24];

  lcfd_store #(
    .Pixels (Pixels)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lcfd_seq #(
    .Pixels (Pixels)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_item_i     (item),
    .latch_ticks_i (latch_ticks_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // Pack result word
  assign m_axis_tdata = {6'h00, res.phase, res.out_byte};
  assign m_axis_tuser = {res.byte_valid, res.status};

endmodule
`default_nettype wire
